// File: rtl/lc3_pkg.sv
package lc3_pkg;

    localparam int          LC3_MEM_WORDS = 65536;
    localparam logic [15:0] FILL_WORD     = 16'h7777;
    localparam logic [15:0] START_RESET   = 16'h3000;
    localparam logic [2:0]  CC_NEG        = 3'b100;
    localparam logic [2:0]  CC_ZERO       = 3'b010;
    localparam logic [2:0]  CC_POS        = 3'b001;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_START = 2'd1,
        ACT_EXEC  = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        OP_BR   = 4'd0,
        OP_ADD  = 4'd1,
        OP_LD   = 4'd2,
        OP_ST   = 4'd3,
        OP_JSR  = 4'd4,
        OP_AND  = 4'd5,
        OP_LDR  = 4'd6,
        OP_STR  = 4'd7,
        OP_RTI  = 4'd8,
        OP_NOT  = 4'd9,
        OP_LDI  = 4'd10,
        OP_STI  = 4'd11,
        OP_JMP  = 4'd12,
        OP_RES  = 4'd13,
        OP_LEA  = 4'd14,
        OP_TRAP = 4'd15
    } t_opcode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDREG,
        ST_FETCH,
        ST_REG1,
        ST_REG2,
        ST_MEM1,
        ST_MEM2
    } t_state;

    typedef struct packed {
        t_action     action;
        logic [15:0] address;
        logic [15:0] data;
        logic [2:0]  reg_select;
    } t_cmd;

    typedef struct packed {
        logic [15:0] pc;
        logic [15:0] ir;
        logic        halted;
        logic        wrote_reg;
        logic [2:0]  dest_reg;
        logic [15:0] reg_value;
        logic        wrote_mem;
        logic [15:0] mem_address;
        logic [15:0] mem_value;
        logic [2:0]  cond_nzp;
    } t_result;

    typedef struct packed {
        logic        we;
        logic [2:0]  waddr;
        logic [15:0] wdata;
        logic [2:0]  raddr;
    } t_rf_req;

    function automatic logic [15:0] sext5(input logic [4:0] v);
        return 16'($signed(v));
    endfunction

    function automatic logic [15:0] sext6(input logic [5:0] v);
        return 16'($signed(v));
    endfunction

    function automatic logic [15:0] sext9(input logic [8:0] v);
        return 16'($signed(v));
    endfunction

    function automatic logic [15:0] sext11(input logic [10:0] v);
        return 16'($signed(v));
    endfunction

    function automatic logic [2:0] nzp_of(input logic [15:0] v);
        logic [2:0] cc;
        if (v[15]) begin
            cc = CC_NEG;
        end else if (v != 16'h0000) begin
            cc = CC_POS;
        end else begin
            cc = CC_ZERO;
        end
        return cc;
    endfunction

endpackage

// File: rtl/lc3_regfile.sv
module lc3_regfile (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lc3_pkg::t_rf_req i_req,
    output logic [15:0]      o_rdata
);
    import lc3_pkg::*;

    logic [15:0] rf_mem [8];
    logic [7:0]  r_valid;
    logic [15:0] r_rdata;
    logic        r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            rf_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= rf_mem[i_req.raddr];
    end

    // a register never written since reset reads as the fill word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
            r_rd_ok <= r_valid[i_req.raddr];
        end
    end

    assign o_rdata = r_rd_ok ? r_rdata : FILL_WORD;

endmodule

// File: rtl/lc3_instruction_executor_top.sv
// channel  | direction | handshake                          | beat
// ---------+-----------+------------------------------------+---------------------------
// command  | in        | start high while busy low          | i_cmd (action, addr, data)
// result   | out       | o_result_valid, one cycle, no hold | o_result
// config   | in        | i_cfg_valid and o_cfg_ready        | i_cfg_data (start address)
//
// after reset the main memory is swept to the fill word, one word per cycle,
// with busy high; config writes are taken during the sweep.
// result is registered once an item ends: write/start/halted execute end on accept,
// register read in rdreg, alu/branch/jump/lea/store/trap in reg2 after fetch, reg1;
// ld/ldr/sti in mem1, ldi in mem2; one-port memory, registered memory/regfile reads.
// busy is low again in the cycle the result is shown; the receiver cannot stall.
module lc3_instruction_executor_top #(
    parameter int MEM_WORDS = lc3_pkg::LC3_MEM_WORDS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  lc3_pkg::t_cmd    i_cmd,
    output logic             o_result_valid,
    output lc3_pkg::t_result o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [15:0]      i_cfg_data
);
    import lc3_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);
    localparam bit POW2 = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
    localparam longint unsigned RECIP = (64'd1 << 32) / MEM_WORDS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_WORDS - 1);

    // reciprocal estimate is low by at most one, fixed by one subtract
    function automatic logic [AW-1:0] wrap(input logic [15:0] a);
        logic [40:0] prod;
        logic [15:0] q;
        logic [32:0] qm;
        logic [17:0] r;
        prod = 41'(a) * 41'(RECIP);
        q    = 16'(prod >> 32);
        qm   = 33'(q) * 33'(MEM_WORDS);
        r    = 18'(a) - 18'(qm);
        if (r >= 18'(MEM_WORDS)) begin
            r = r - 18'(MEM_WORDS);
        end
        if (POW2) begin
            return AW'(a);
        end
        return AW'(r);
    endfunction

    t_state      r_state, n_state;
    logic [15:0] r_pc;
    logic [2:0]  r_cc;
    logic        r_halt;
    logic [15:0] r_start_addr;
    logic [AW-1:0] r_clr_addr;
    logic [15:0] r_ir;
    logic [15:0] r_base;
    logic [15:0] r_opb;
    logic [2:0]  r_sel;
    t_result     r_res;
    logic        r_res_valid;

    logic [15:0] mem [MEM_WORDS];
    logic [15:0] r_mem_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [15:0]   mem_wdata;

    t_rf_req     rf_req;
    logic [15:0] rf_rdata;

    logic          accept;
    logic          fin;
    t_result       n_res;
    logic [AW-1:0] f_maddr;
    logic [AW-1:0] rd_addr;
    logic [2:0]    rf_raddr;
    logic [15:0]   alu_b;

    t_opcode     op;
    logic [15:0] pc1;
    logic [15:0] pcoff;
    logic [15:0] baseoff;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign op      = t_opcode'(r_ir[15:12]);
    assign pc1     = r_pc + 16'd1;
    assign pcoff   = pc1 + sext9(r_ir[8:0]);
    assign baseoff = r_base + sext6(r_ir[5:0]);
    assign alu_b   = r_ir[5] ? sext5(r_ir[4:0]) : rf_rdata;

    lc3_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rf_req),
        .o_rdata (rf_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd.action)
                        ACT_READ: n_state = ST_RDREG;
                        ACT_EXEC: n_state = r_halt ? ST_IDLE : ST_FETCH;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RDREG: n_state = ST_IDLE;
            ST_FETCH: n_state = ST_REG1;
            ST_REG1:  n_state = ST_REG2;
            ST_REG2: begin
                case (op)
                    OP_LD, OP_LDR, OP_LDI, OP_STI: n_state = ST_MEM1;
                    default:                       n_state = ST_IDLE;
                endcase
            end
            ST_MEM1:  n_state = (op == OP_LDI) ? ST_MEM2 : ST_IDLE;
            ST_MEM2:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        fin               = 1'b0;
        n_res             = '0;
        n_res.pc          = r_pc;
        n_res.halted      = r_halt;
        n_res.cond_nzp    = r_cc;
        f_maddr           = '0;
        rd_addr           = '0;
        rf_raddr          = 3'd0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd.action)
                        ACT_WRITE: begin
                            fin               = 1'b1;
                            f_maddr           = wrap(i_cmd.address);
                            n_res.wrote_mem   = 1'b1;
                            n_res.mem_address = 16'(f_maddr);
                            n_res.mem_value   = i_cmd.data;
                        end
                        ACT_START: begin
                            fin          = 1'b1;
                            n_res.pc     = r_start_addr;
                            n_res.halted = 1'b0;
                        end
                        ACT_EXEC: begin
                            fin     = r_halt;
                            rd_addr = wrap(r_pc);
                        end
                        ACT_READ: begin
                            rf_raddr = i_cmd.reg_select;
                        end
                        default: begin
                            fin = 1'b0;
                        end
                    endcase
                end
            end
            ST_RDREG: begin
                fin             = 1'b1;
                n_res.dest_reg  = r_sel;
                n_res.reg_value = rf_rdata;
            end
            ST_FETCH: begin
                rf_raddr = r_mem_rdata[8:6];
            end
            ST_REG1: begin
                case (op)
                    OP_ST, OP_STI, OP_STR: rf_raddr = r_ir[11:9];
                    default:               rf_raddr = r_ir[2:0];
                endcase
            end
            ST_REG2: begin
                n_res.ir = r_ir;
                n_res.pc = pc1;
                fin      = 1'b1;
                case (op)
                    OP_ADD, OP_AND: begin
                        n_res.wrote_reg = 1'b1;
                        n_res.dest_reg  = r_ir[11:9];
                        n_res.reg_value = (op == OP_ADD) ? (r_base + alu_b) : (r_base & alu_b);
                        n_res.cond_nzp  = nzp_of(n_res.reg_value);
                    end
                    OP_NOT: begin
                        n_res.wrote_reg = 1'b1;
                        n_res.dest_reg  = r_ir[11:9];
                        n_res.reg_value = ~r_base;
                        n_res.cond_nzp  = nzp_of(n_res.reg_value);
                    end
                    OP_BR: begin
                        if ((r_ir[11:9] & r_cc) != 3'b000) begin
                            n_res.pc = pcoff;
                        end
                    end
                    OP_JMP: begin
                        n_res.pc = r_base;
                    end
                    OP_JSR: begin
                        // base was read before the link write, so jsrr r7 works
                        n_res.pc        = r_ir[11] ? (pc1 + sext11(r_ir[10:0])) : r_base;
                        n_res.wrote_reg = 1'b1;
                        n_res.dest_reg  = 3'd7;
                        n_res.reg_value = pc1;
                    end
                    OP_LEA: begin
                        n_res.wrote_reg = 1'b1;
                        n_res.dest_reg  = r_ir[11:9];
                        n_res.reg_value = pcoff;
                    end
                    OP_LD, OP_LDI, OP_STI: begin
                        fin     = 1'b0;
                        rd_addr = wrap(pcoff);
                    end
                    OP_LDR: begin
                        fin     = 1'b0;
                        rd_addr = wrap(baseoff);
                    end
                    OP_ST, OP_STR: begin
                        f_maddr           = wrap((op == OP_ST) ? pcoff : baseoff);
                        n_res.wrote_mem   = 1'b1;
                        n_res.mem_address = 16'(f_maddr);
                        n_res.mem_value   = rf_rdata;
                    end
                    OP_TRAP: begin
                        n_res.halted = 1'b1;
                    end
                    default: begin
                        n_res.pc = pc1;
                    end
                endcase
            end
            ST_MEM1: begin
                n_res.ir = r_ir;
                n_res.pc = pc1;
                case (op)
                    OP_LDI: begin
                        rd_addr = wrap(r_mem_rdata);
                    end
                    OP_STI: begin
                        fin               = 1'b1;
                        f_maddr           = wrap(r_mem_rdata);
                        n_res.wrote_mem   = 1'b1;
                        n_res.mem_address = 16'(f_maddr);
                        n_res.mem_value   = r_opb;
                    end
                    default: begin
                        fin             = 1'b1;
                        n_res.wrote_reg = 1'b1;
                        n_res.dest_reg  = r_ir[11:9];
                        n_res.reg_value = r_mem_rdata;
                        n_res.cond_nzp  = nzp_of(r_mem_rdata);
                    end
                endcase
            end
            ST_MEM2: begin
                fin             = 1'b1;
                n_res.ir        = r_ir;
                n_res.pc        = pc1;
                n_res.wrote_reg = 1'b1;
                n_res.dest_reg  = r_ir[11:9];
                n_res.reg_value = r_mem_rdata;
                n_res.cond_nzp  = nzp_of(r_mem_rdata);
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    // single memory port: clearing sweep, then stores, then reads
    always_comb begin
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_addr  = r_clr_addr;
            mem_wdata = FILL_WORD;
        end else begin
            mem_we    = fin && n_res.wrote_mem;
            mem_addr  = (fin && n_res.wrote_mem) ? f_maddr : rd_addr;
            mem_wdata = n_res.mem_value;
        end
    end

    always_comb begin
        rf_req.we    = fin && n_res.wrote_reg;
        rf_req.waddr = n_res.dest_reg;
        rf_req.wdata = n_res.reg_value;
        rf_req.raddr = rf_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_mem_rdata <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_pc         <= START_RESET;
            r_cc         <= CC_ZERO;
            r_halt       <= 1'b0;
            r_start_addr <= START_RESET;
            r_clr_addr   <= '0;
            r_res_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= fin;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_start_addr <= i_cfg_data;
            end
            if (fin) begin
                r_pc   <= n_res.pc;
                r_cc   <= n_res.cond_nzp;
                r_halt <= n_res.halted;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_res <= n_res;
        end
        if (accept) begin
            r_sel <= i_cmd.reg_select;
        end
        case (r_state)
            ST_FETCH: r_ir   <= r_mem_rdata;
            ST_REG1:  r_base <= rf_rdata;
            ST_REG2:  r_opb  <= rf_rdata;
            default:  r_ir   <= r_ir;
        endcase
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

    a_result_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while an item is still in progress");

    a_one_store_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_result.wrote_reg && o_result.wrote_mem))
        else $error("register and memory both written by one item");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_result_valid && !fin)
        else $error("result produced during the memory sweep");

    a_unused_mem_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.wrote_mem) |->
            (o_result.mem_address == 16'h0000) && (o_result.mem_value == 16'h0000))
        else $error("store fields nonzero without a store");

endmodule

// File: verif/tb_lc3_instruction_executor_top.sv
`timescale 1ns / 1ps

module tb_lc3_instruction_executor_top;
    import lc3_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        t_cmd    cmd;
        bit      typed;
        t_result want;
    } t_plan_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_cmd        i_cmd;
    logic        o_result_valid;
    t_result     o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    // shadow copy of the core's architectural state
    logic [15:0] shadow_mem [0:65535];
    logic [15:0] shadow_regs [0:7];
    logic [15:0] shadow_pc;
    logic [2:0]  shadow_cc;
    logic        shadow_halt;
    logic [15:0] shadow_origin;

    t_plan_row   plan[$];
    t_result     pending_results[$];
    t_result     oldest;
    int          mismatches = 0;
    int          cycles = 0;

    lc3_instruction_executor_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic t_cmd mk_cmd(input t_action act, input logic [15:0] adr,
                                    input logic [15:0] dat, input logic [2:0] sel);
        t_cmd c;
        c.action     = act;
        c.address    = adr;
        c.data       = dat;
        c.reg_select = sel;
        return c;
    endfunction

    // unused fields carry random junk
    function automatic t_cmd rand_cmd(input t_action act);
        return mk_cmd(act, 16'($urandom), 16'($urandom), 3'($urandom_range(0, 7)));
    endfunction

    task automatic add_row(input t_cmd c, input bit typed, input t_result want);
        t_plan_row row;
        row.cmd   = c;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    task automatic core_step(input t_cmd c, output t_result r);
        logic [15:0] ir, npc, base, opb, res, maddr, off9, off6;
        logic [2:0]  dr;
        logic        wreg, wmem, setcc;
        t_opcode     op;
        r = '0;
        case (c.action)
            ACT_WRITE: begin
                shadow_mem[c.address] = c.data;
                r.wrote_mem   = 1'b1;
                r.mem_address = c.address;
                r.mem_value   = c.data;
            end
            ACT_START: begin
                shadow_pc   = shadow_origin;
                shadow_halt = 1'b0;
            end
            ACT_READ: begin
                r.dest_reg  = c.reg_select;
                r.reg_value = shadow_regs[c.reg_select];
            end
            default: begin
                if (!shadow_halt) begin
                    ir    = shadow_mem[shadow_pc];
                    npc   = shadow_pc + 16'd1;
                    op    = t_opcode'(ir[15:12]);
                    dr    = ir[11:9];
                    base  = shadow_regs[ir[8:6]];
                    off9  = {{7{ir[8]}}, ir[8:0]};
                    off6  = {{10{ir[5]}}, ir[5:0]};
                    res   = '0;
                    maddr = '0;
                    wreg  = 1'b0;
                    wmem  = 1'b0;
                    setcc = 1'b0;
                    case (op)
                        OP_ADD, OP_AND: begin
                            opb = ir[5] ? {{11{ir[4]}}, ir[4:0]} : shadow_regs[ir[2:0]];
                            res = (op == OP_ADD) ? base + opb : base & opb;
                            wreg = 1'b1;
                            setcc = 1'b1;
                        end
                        OP_NOT: begin
                            res = ~base;
                            wreg = 1'b1;
                            setcc = 1'b1;
                        end
                        OP_BR: begin
                            if ((ir[11:9] & shadow_cc) != 3'b000) begin
                                npc = npc + off9;
                            end
                        end
                        OP_JMP: begin
                            npc = base;
                        end
                        OP_JSR: begin
                            // link value is taken before the jump, base before R7 changes
                            res = npc;
                            npc = ir[11] ? npc + {{5{ir[10]}}, ir[10:0]} : base;
                            dr = 3'd7;
                            wreg = 1'b1;
                        end
                        OP_LD: begin
                            res = shadow_mem[npc + off9];
                            wreg = 1'b1;
                            setcc = 1'b1;
                        end
                        OP_LDI: begin
                            res = shadow_mem[shadow_mem[npc + off9]];
                            wreg = 1'b1;
                            setcc = 1'b1;
                        end
                        OP_LDR: begin
                            res = shadow_mem[base + off6];
                            wreg = 1'b1;
                            setcc = 1'b1;
                        end
                        OP_LEA: begin
                            res = npc + off9;
                            wreg = 1'b1;
                        end
                        OP_ST: begin
                            maddr = npc + off9;
                            wmem = 1'b1;
                        end
                        OP_STI: begin
                            maddr = shadow_mem[npc + off9];
                            wmem = 1'b1;
                        end
                        OP_STR: begin
                            maddr = base + off6;
                            wmem = 1'b1;
                        end
                        OP_TRAP: begin
                            shadow_halt = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                    if (wmem) begin
                        shadow_mem[maddr] = shadow_regs[dr];
                        r.wrote_mem   = 1'b1;
                        r.mem_address = maddr;
                        r.mem_value   = shadow_regs[dr];
                    end
                    if (wreg) begin
                        shadow_regs[dr] = res;
                        r.wrote_reg = 1'b1;
                        r.dest_reg  = dr;
                        r.reg_value = res;
                        if (setcc) begin
                            shadow_cc = res[15] ? CC_NEG : (res != 16'h0000 ? CC_POS : CC_ZERO);
                        end
                    end
                    shadow_pc = npc;
                    r.ir = ir;
                end
            end
        endcase
        r.pc       = shadow_pc;
        r.halted   = shadow_halt;
        r.cond_nzp = shadow_cc;
    endtask

    // one beat per command, expectation queued once busy is seen low after an edge
    task automatic issue(input t_cmd c, input bit typed, input t_result want);
        t_result r;
        i_cmd <= c;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        core_step(c, r);
        pending_results.push_back(typed ? want : r);
    endtask

    task automatic pause(input int pct);
        if (pct != 0 && $urandom_range(99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic set_origin(input logic [15:0] value);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_origin = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int n, input int pct);
        int          done;
        int          pick;
        bit          idle_exec;
        t_cmd        c;
        logic [15:0] spot;
        done = 0;
        while (done < n) begin
            pick = $urandom_range(99);
            if (shadow_halt && pick < 50) begin
                issue(rand_cmd(ACT_START), 1'b0, '0);
                done++;
            end else if (pick < 45) begin
                // plant a random instruction at the current pc, then run it
                c = rand_cmd(ACT_WRITE);
                c.address = shadow_pc;
                issue(c, 1'b0, '0);
                pause(pct);
                issue(rand_cmd(ACT_EXEC), 1'b0, '0);
                done += 2;
            end else if (pick < 60) begin
                idle_exec = shadow_halt;
                issue(rand_cmd(ACT_EXEC), 1'b0, '0);
                if (!idle_exec) done++;
            end else if (pick < 72) begin
                // data words near the pc for loads to pick up
                spot = shadow_pc + 16'($urandom_range(0, 40)) - 16'd20;
                c = rand_cmd(ACT_WRITE);
                c.address = spot;
                issue(c, 1'b0, '0);
                done++;
            end else if (pick < 85) begin
                issue(rand_cmd(ACT_READ), 1'b0, '0);
                done++;
            end else if (pick < 90) begin
                issue(rand_cmd(ACT_START), 1'b0, '0);
                done++;
            end else begin
                issue(rand_cmd(ACT_WRITE), 1'b0, '0);
                done++;
            end
            pause(pct);
        end
        start <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, actual %p", $time, o_result);
                mismatches++;
            end else begin
                oldest = pending_results.pop_front();
                check_field("pc", oldest.pc, o_result.pc);
                check_field("ir", oldest.ir, o_result.ir);
                check_field("halted", 16'(oldest.halted), 16'(o_result.halted));
                check_field("wrote_reg", 16'(oldest.wrote_reg), 16'(o_result.wrote_reg));
                check_field("dest_reg", 16'(oldest.dest_reg), 16'(o_result.dest_reg));
                check_field("reg_value", oldest.reg_value, o_result.reg_value);
                check_field("wrote_mem", 16'(oldest.wrote_mem), 16'(o_result.wrote_mem));
                check_field("mem_address", oldest.mem_address, o_result.mem_address);
                check_field("mem_value", oldest.mem_value, o_result.mem_value);
                check_field("cond_nzp", 16'(oldest.cond_nzp), 16'(o_result.cond_nzp));
            end
        end
    end

    initial begin
        t_result w;
        for (int i = 0; i < 65536; i++) shadow_mem[i] = FILL_WORD;
        for (int i = 0; i < 8; i++) shadow_regs[i] = FILL_WORD;
        shadow_pc     = START_RESET;
        shadow_cc     = CC_ZERO;
        shadow_halt   = 1'b0;
        shadow_origin = START_RESET;

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_cmd       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // taken while the memory clear is still running
        set_origin(16'hFFFF);

        // register reads straight after reset
        w = '0;
        w.pc        = START_RESET;
        w.reg_value = FILL_WORD;
        w.cond_nzp  = CC_ZERO;
        add_row(mk_cmd(ACT_READ, 16'h0000, 16'h0000, 3'd0), 1'b1, w);
        w.dest_reg  = 3'd7;
        add_row(mk_cmd(ACT_READ, 16'hFFFF, 16'hFFFF, 3'd7), 1'b1, w);
        // address and data extremes; top word is a trap, word 0 a never-taken branch
        w = '0;
        w.pc          = START_RESET;
        w.cond_nzp    = CC_ZERO;
        w.wrote_mem   = 1'b1;
        w.mem_address = 16'hFFFF;
        w.mem_value   = 16'hFFFF;
        add_row(mk_cmd(ACT_WRITE, 16'hFFFF, 16'hFFFF, 3'd5), 1'b1, w);
        w.mem_address = 16'h0000;
        w.mem_value   = 16'h0000;
        add_row(mk_cmd(ACT_WRITE, 16'h0000, 16'h0000, 3'd2), 1'b1, w);
        // fill word decodes as a store through a register
        add_row(mk_cmd(ACT_EXEC, 16'h0000, 16'h0000, 3'd0), 1'b0, '0);
        add_row(mk_cmd(ACT_START, 16'h1234, 16'hABCD, 3'd4), 1'b0, '0);
        // trap at the top word, pc wraps to zero
        add_row(mk_cmd(ACT_EXEC, 16'h0000, 16'h0000, 3'd0), 1'b0, '0);
        // halted: execute does nothing, write and read still work
        add_row(mk_cmd(ACT_EXEC, 16'hFFFF, 16'hFFFF, 3'd7), 1'b0, '0);
        add_row(mk_cmd(ACT_WRITE, 16'hFFFF, 16'h0000, 3'd0), 1'b0, '0);
        add_row(mk_cmd(ACT_READ, 16'h0000, 16'h0000, 3'd3), 1'b0, '0);
        add_row(mk_cmd(ACT_WRITE, 16'h0000, 16'h1270, 3'd0), 1'b0, '0);
        add_row(mk_cmd(ACT_WRITE, 16'h0001, 16'h5498, 3'd0), 1'b0, '0);
        add_row(mk_cmd(ACT_WRITE, 16'h0002, 16'h987F, 3'd0), 1'b0, '0);
        add_row(mk_cmd(ACT_WRITE, 16'h0003, 16'h41C0, 3'd0), 1'b0, '0);
        add_row(mk_cmd(ACT_START, 16'h0000, 16'h0000, 3'd0), 1'b0, '0);
        // branch with empty nzp, add with most negative imm5, and with
        // ignored bits, not with ignored low bits, jsrr through r7
        for (int i = 0; i < 6; i++) begin
            add_row(mk_cmd(ACT_EXEC, 16'h0000, 16'h0000, 3'd0), 1'b0, '0);
        end
        add_row(mk_cmd(ACT_READ, 16'h0000, 16'h0000, 3'd4), 1'b0, '0);
        add_row(mk_cmd(ACT_READ, 16'h0000, 16'h0000, 3'd7), 1'b0, '0);

        foreach (plan[i]) issue(plan[i].cmd, plan[i].typed, plan[i].want);
        start <= 1'b0;

        drain();
        set_origin(16'h0000);
        run_phase(600, 9);
        drain();
        set_origin(16'($urandom_range(1, 16'hFFFE)));
        run_phase(600, 46);
        drain();
        set_origin(START_RESET);
        run_phase(600, 0);
        drain();
        repeat (8) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
